// ===== hw/rtl/fast_corner_score_macros.svh =====
// Assertion macros used by the checker file of the corner score block.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef FAST_CORNER_SCORE_MACROS_SVH
`define FAST_CORNER_SCORE_MACROS_SVH

// Checked at every rising edge of clk while rst_n is high.
`define FCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define FCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fcs_pkg.sv =====
// Package of the FAST corner score block: sizes, constants and state encoding.
// Used by fast_corner_score and fcs_checker; depends on nothing.
package fcs_pkg;

  localparam int CIRCLE_POINTS = 16;
  localparam int PIXEL_BITS    = 8;
  localparam int ARC_LEN       = 9;
  localparam int SCORE_MAX     = 255;
  localparam int SCORE_W       = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } fcs_state_t;

endpackage

// ===== hw/rtl/fast_corner_score.sv =====
// FAST-9 corner score over the sixteen-point circle; depends on fcs_pkg.
// Throughput: other points are taken one per cycle; after the last point the input
// stalls until the score is loaded for output. The score pass reads the difference
// memory once per entry, then rotates a window and scores one nine-point arc per cycle.
// Reset: synchronous, active low; clears the point count, state and output valid.
module fast_corner_score #(
  parameter int PIXEL_BITS = fcs_pkg::PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [PIXEL_BITS-1:0]              in_center_pixel,
  input  logic [PIXEL_BITS-1:0]              in_circle_pixel,
  input  logic                               in_last_point,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fcs_pkg::SCORE_W-1:0] out_corner_score
);

  localparam int DW    = PIXEL_BITS + 1;
  localparam int NPTS  = fcs_pkg::CIRCLE_POINTS;
  localparam int IDX_W = $clog2(NPTS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic signed [DW-1:0] DIFF_MAX = {1'b0, {PIXEL_BITS{1'b1}}};
  localparam logic signed [DW:0]   SAT      = (DW+1)'(fcs_pkg::SCORE_MAX);

  fcs_pkg::fcs_state_t state_r, state_nxt;

  logic signed [DW-1:0] mem [NPTS];
  logic signed [DW-1:0] rdata_r;
  logic signed [DW-1:0] win_r [NPTS];
  logic signed [DW-1:0] lo_r, lo_nxt;
  logic signed [DW-1:0] mx_r, mx_nxt;
  logic [IDX_W-1:0]     pc_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r;
  logic signed [fcs_pkg::SCORE_W-1:0] score_r;

  logic in_acc;
  logic out_free;
  logic load_go;
  logic shift_load;
  logic rotate;
  logic out_load;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] arc_min;
  logic signed [DW-1:0] arc_max;
  logic signed [DW:0]   hi;
  logic signed [DW:0]   neg_lo;
  logic signed [DW:0]   sc;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign diff     = $signed({1'b0, in_center_pixel}) - $signed({1'b0, in_circle_pixel});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fcs_pkg::ST_IDLE: begin
        if (in_acc && in_last_point) state_nxt = fcs_pkg::ST_LOAD;
      end
      fcs_pkg::ST_LOAD: begin
        if (cnt_r == CNT_W'(NPTS)) state_nxt = fcs_pkg::ST_SCAN;
      end
      fcs_pkg::ST_SCAN: begin
        if (cnt_r == CNT_W'(NPTS - 1)) state_nxt = fcs_pkg::ST_DONE;
      end
      fcs_pkg::ST_DONE: begin
        if (out_free) state_nxt = fcs_pkg::ST_IDLE;
      end
      default: state_nxt = fcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    load_go    = 1'b0;
    shift_load = 1'b0;
    rotate     = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      fcs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        load_go  = in_acc && in_last_point;
      end
      fcs_pkg::ST_LOAD: begin
        shift_load = (cnt_r != '0);
      end
      fcs_pkg::ST_SCAN: begin
        rotate = 1'b1;
      end
      fcs_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    arc_min = win_r[0];
    arc_max = win_r[0];
    for (int i = 1; i < fcs_pkg::ARC_LEN; i++) begin
      if (win_r[i] < arc_min) arc_min = win_r[i];
      if (win_r[i] > arc_max) arc_max = win_r[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(1);
    if (load_go || (state_r == fcs_pkg::ST_LOAD && cnt_r == CNT_W'(NPTS))) begin
      cnt_nxt = '0;
    end
    lo_nxt = lo_r;
    mx_nxt = mx_r;
    if (state_r == fcs_pkg::ST_LOAD) begin
      lo_nxt = '0;
      mx_nxt = DIFF_MAX;
    end else if (rotate) begin
      if (arc_min > lo_r) lo_nxt = arc_min;
      if (arc_max < mx_r) mx_nxt = arc_max;
    end
  end

  always_comb begin
    neg_lo = -$signed({lo_r[DW-1], lo_r});
    hi     = ($signed({mx_r[DW-1], mx_r}) < neg_lo) ? $signed({mx_r[DW-1], mx_r}) : neg_lo;
    sc     = -hi - (DW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[pc_r] <= diff;
    end
    rdata_r <= mem[cnt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (shift_load) begin
      for (int i = 0; i < NPTS - 1; i++) win_r[i] <= win_r[i+1];
      win_r[NPTS-1] <= rdata_r;
    end else if (rotate) begin
      for (int i = 0; i < NPTS - 1; i++) win_r[i] <= win_r[i+1];
      win_r[NPTS-1] <= win_r[0];
    end
    lo_r  <= lo_nxt;
    mx_r  <= mx_nxt;
    cnt_r <= cnt_nxt;
    if (out_load) begin
      score_r <= (sc > SAT) ? SAT[fcs_pkg::SCORE_W-1:0] : sc[fcs_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcs_pkg::ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        pc_r <= in_last_point ? '0 : pc_r + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_corner_score = score_r;

endmodule

// ===== hw/rtl/fcs_checker.sv =====
// Port-level checker for fast_corner_score, attached by the bind at the end.
// Depends on fcs_pkg and fast_corner_score_macros.svh.
`include "fast_corner_score_macros.svh"

module fcs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_last_point,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [fcs_pkg::SCORE_W-1:0] out_corner_score
);

  // A stalled result transaction keeps its score.
  `FCS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_corner_score), "stalled result changed")

  // A point other than the last leaves the input side open.
  `FCS_ASSERT(a_point_open, in_valid && !in_stall && !in_last_point |=> !in_stall, "input closed after a point")

  // The last point starts the score pass, which closes the input side.
  `FCS_ASSERT(a_last_closes, in_valid && !in_stall && in_last_point |=> in_stall, "input open after last point")

  // A new result appears only at the end of a score pass.
  `FCS_ASSERT(a_result_after_pass, $rose(out_valid) |-> $past(in_stall), "result without score pass")

  // Reset clears the result channel.
  `FCS_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fast_corner_score fcs_checker u_fcs_checker (.*);

// ===== tb/sv/tb_fast_corner_score.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of fast_corner_score: a directed table of points, then random
// corners, every score checked against a FAST-9 predictor kept in this file, or against
// the score typed in a table row. Depends on fcs_pkg and the fast_corner_score RTL only.
module tb_fast_corner_score;

  localparam int RANDOM_ITEMS = 1550;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;

  typedef logic signed [fcs_pkg::SCORE_W-1:0] score_t;

  typedef struct packed {
    logic [fcs_pkg::PIXEL_BITS-1:0] center;
    logic [fcs_pkg::PIXEL_BITS-1:0] circle;
    logic                           last;
    logic                           typed;
    score_t                         score;
  } point_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [fcs_pkg::PIXEL_BITS-1:0] in_center_pixel = '0;
  logic [fcs_pkg::PIXEL_BITS-1:0] in_circle_pixel = '0;
  logic                           in_last_point = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  score_t                         out_corner_score;

  int     point_diff [fcs_pkg::CIRCLE_POINTS];
  int     next_slot = 0;
  score_t score_expected [$];
  int     fail_count = 0;
  int     items_sent = 0;
  int     idle_cycles = 0;
  int     stall_left = 0;
  bit     quiet = 1'b0;

  fast_corner_score dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_center_pixel  (in_center_pixel),
    .in_circle_pixel  (in_circle_pixel),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_corner_score (out_corner_score)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic score_t fast_score_of();
    int lo, hi, arc_min, arc_max, v;
    lo = 0;
    for (int a = 0; a < fcs_pkg::CIRCLE_POINTS; a++) begin
      arc_min = point_diff[a];
      for (int j = 1; j < fcs_pkg::ARC_LEN; j++) begin
        if (point_diff[(a + j) % fcs_pkg::CIRCLE_POINTS] < arc_min)
          arc_min = point_diff[(a + j) % fcs_pkg::CIRCLE_POINTS];
      end
      if (arc_min > lo) lo = arc_min;
    end
    hi = -lo;
    for (int a = 0; a < fcs_pkg::CIRCLE_POINTS; a++) begin
      arc_max = point_diff[a];
      for (int j = 1; j < fcs_pkg::ARC_LEN; j++) begin
        if (point_diff[(a + j) % fcs_pkg::CIRCLE_POINTS] > arc_max)
          arc_max = point_diff[(a + j) % fcs_pkg::CIRCLE_POINTS];
      end
      if (arc_max < hi) hi = arc_max;
    end
    v = -hi - 1;
    if (v > fcs_pkg::SCORE_MAX) v = fcs_pkg::SCORE_MAX;
    return score_t'(v);
  endfunction

  // Drives one transaction, waits for it to be taken, updates the predictor, then may idle.
  task automatic send_point(input point_row_t p);
    score_t s;
    int     gap;
    in_valid        <= 1'b1;
    in_center_pixel <= p.center;
    in_circle_pixel <= p.circle;
    in_last_point   <= p.last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    point_diff[next_slot] = int'(p.center) - int'(p.circle);
    if (p.last) begin
      next_slot = 0;
      s = fast_score_of();
      score_expected.push_back(p.typed ? p.score : s);
    end else begin
      next_slot = (next_slot + 1) % fcs_pkg::CIRCLE_POINTS;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_scores();
    in_valid <= 1'b0;
    while (score_expected.size() != 0) @(posedge clk);
  endtask

  function automatic point_row_t mk_row(int c, int p, bit l, bit t = 1'b0, int s = 0);
    point_row_t r;
    r.center = c[fcs_pkg::PIXEL_BITS-1:0];
    r.circle = p[fcs_pkg::PIXEL_BITS-1:0];
    r.last   = l;
    r.typed  = t;
    r.score  = score_t'(s);
    return r;
  endfunction

  task automatic send_corner();
    int mode, c, n, start, span, sign, pix;
    bit in_arc;
    mode = $urandom_range(0, 99);
    c = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255);
    n = fcs_pkg::CIRCLE_POINTS;
    if (mode >= 80 && mode < 90) n = $urandom_range(1, 15);
    else if (mode >= 90) n = $urandom_range(17, 24);
    start = $urandom_range(0, 15);
    span  = $urandom_range(6, 16);
    sign  = $urandom_range(0, 1) ? 1 : -1;
    for (int k = 0; k < n; k++) begin
      in_arc = ((k - start + 2 * fcs_pkg::CIRCLE_POINTS) % fcs_pkg::CIRCLE_POINTS) < span;
      if (mode < 5) begin
        pix = c;
      end else if (mode < 20 || !in_arc) begin
        pix = $urandom_range(0, 255);
      end else begin
        pix = c + sign * ($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(1, 60));
        if (pix < 0) pix = 0;
        if (pix > 255) pix = 255;
      end
      send_point(mk_row(c, pix, k == n - 1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (score_expected.size() == 0) begin
          $error("unexpected transaction: corner_score actual %0d", out_corner_score);
          fail_count++;
        end else if (out_corner_score !== score_expected[0]) begin
          $error("corner_score mismatch: expected %0d, actual %0d",
                 score_expected[0], out_corner_score);
          fail_count++;
          void'(score_expected.pop_front());
        end else begin
          void'(score_expected.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    point_row_t directed_rows [$];
    for (int i = 0; i < fcs_pkg::CIRCLE_POINTS - 1; i++) begin
      directed_rows.push_back(mk_row(255, 0, 1'b0));
    end
    directed_rows.push_back(mk_row(255, 0, 1'b1, 1'b1, 254));
    directed_rows.push_back(mk_row(0, 255, 1'b1));
    directed_rows.push_back(mk_row(0, 0, 1'b0));
    directed_rows.push_back(mk_row(128, 128, 1'b1));
    directed_rows.push_back(mk_row(1, 254, 1'b0));
    directed_rows.push_back(mk_row(127, 128, 1'b0));
    directed_rows.push_back(mk_row(200, 55, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send_point(directed_rows[i]);
    drain_scores();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 9) == 0);
      send_corner();
      if ($urandom_range(0, 19) == 0) drain_scores();
    end
    quiet = 1'b0;
    drain_scores();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
